### rtl/quemada_viscous_stress_macros.svh
// Assertion helpers for the RTL of the viscous stress unit
`ifndef QUEMADA_VISCOUS_STRESS_MACROS_SVH
`define QUEMADA_VISCOUS_STRESS_MACROS_SVH

// Same-cycle implication, checked out of reset
`define QVS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define QVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qvs_pkg.sv
package qvs_pkg;

    localparam int DATA_W   = 32;
    localparam int VAL_W    = 31;
    localparam int FRAC_W   = 16;
    localparam int H_W      = 17;
    localparam int N_COMP   = 6;

    localparam logic [VAL_W-1:0] VAL_MAX  = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] ONE_FX   = VAL_W'(32'h0001_0000);
    // floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
    localparam logic [31:0]      RECIP3   = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        REG_MU0  = 3'd0,
        REG_H    = 3'd1,
        REG_K0   = 3'd2,
        REG_KINF = 3'd3,
        REG_GC   = 3'd4
    } t_reg_index;

    // Per-component magnitude and sign carried along the pipeline
    typedef struct packed {
        logic [N_COMP-1:0]             neg;
        logic [N_COMP-1:0][DATA_W-1:0] mag;
    } t_comp;

endpackage

### rtl/qvs_isqrt.sv
module qvs_isqrt #(
    parameter int IW = 67,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IW-1:0]         i_rad,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [(IW+1)/2-1:0]   o_root,
    output logic [SW-1:0]         o_side
);
    localparam int OW = (IW + 1) / 2;
    localparam int XW = 2 * OW;
    localparam int RW = OW + 3;

    logic            r_v    [0:OW-1];
    logic [XW-1:0]   r_x    [0:OW-1];
    logic [RW-1:0]   r_rem  [0:OW-1];
    logic [OW-1:0]   r_root [0:OW-1];
    logic [SW-1:0]   r_side [0:OW-1];

    // One root bit per stage, most significant first
    for (genvar j = 0; j < OW; j++) begin : g_stage
        logic          s_v;
        logic [XW-1:0] s_x;
        logic [RW-1:0] s_rem;
        logic [OW-1:0] s_root;
        logic [SW-1:0] s_side;
        logic [RW-1:0] n_remsh;
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_rem;
        logic [OW-1:0] n_root;
        logic          n_ge;

        if (j == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_x    = XW'(i_rad);
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[j-1];
            assign s_x    = r_x[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_root = r_root[j-1];
            assign s_side = r_side[j-1];
        end

        // Bring down two radicand bits and try the next root bit
        always_comb begin
            n_remsh = {s_rem[RW-3:0], s_x[XW-1 -: 2]};
            n_trial = RW'({s_root, 2'b01});
            n_ge    = (n_remsh >= n_trial);
            n_rem   = n_ge ? (n_remsh - n_trial) : n_remsh;
            n_root  = {s_root[OW-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]    <= s_x << 2;
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
                r_side[j] <= s_side;
            end
        end
    end

    assign o_valid = r_v[OW-1];
    assign o_root  = r_root[OW-1];
    assign o_side  = r_side[OW-1];

endmodule

### rtl/qvs_divu.sv
module qvs_divu #(
    parameter int NW = 50,
    parameter int DW = 31,
    parameter int QW = 50,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic            r_v    [0:QW-1];
    logic [CW-1:0]   r_rem  [0:QW-1];
    logic [DW-1:0]   r_d    [0:QW-1];
    logic [QW-1:0]   r_q    [0:QW-1];
    logic [SW-1:0]   r_side [0:QW-1];

    // Restoring division, one quotient bit per stage, most significant first
    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic          s_v;
        logic [CW-1:0] s_rem;
        logic [DW-1:0] s_d;
        logic [QW-1:0] s_q;
        logic [SW-1:0] s_side;
        logic [CW-1:0] n_sub;
        logic [CW-1:0] n_rem;
        logic [QW-1:0] n_q;
        logic          n_ge;

        if (j == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = CW'(i_num);
            assign s_d    = i_den;
            assign s_q    = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_d    = r_d[j-1];
            assign s_q    = r_q[j-1];
            assign s_side = r_side[j-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb begin
            n_sub = CW'(s_d) << B;
            n_ge  = (s_rem >= n_sub);
            n_rem = n_ge ? (s_rem - n_sub) : s_rem;
            n_q   = {s_q[QW-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_d[j]    <= s_d;
                r_q[j]    <= n_q;
                r_side[j] <= s_side;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

### rtl/quemada_viscous_stress.sv
// Pipeline: the bit-serial pipelines of two square roots and three dividers
// (one bit per stage) lie between input transfer and result.
// Throughput: one tensor per cycle; a stalled output stops the whole pipeline
// only once the last stage holds an item, so inputs are still taken until then.
// Reset (synchronous, active low) clears all valid bits and loads the
// registers with mu0 = H = k0 = kinf = 0 and critical rate 1.0.
`include "quemada_viscous_stress_macros.svh"

module quemada_viscous_stress (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // d_xx, d_yy, d_zz, d_xy, d_yz, d_xz: 32 b each from bit 0
    input  logic [191:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // s_xx, s_yy, s_zz, s_xy, s_yz, s_xz (32 b each), shear_visc (31 b),
    // bulk_visc (31 b), saturated (1 b), one zero pad bit
    output logic [255:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import qvs_pkg::*;

    localparam int CMP_W = $bits(t_comp);

    // Configuration registers
    logic [VAL_W-1:0] r_mu0, r_k0, r_kinf, r_gc;
    logic [H_W-1:0]   r_h;

    // Derived constants of the current configuration
    logic [VAL_W-1:0] w_gc_eff;
    logic             w_diff_neg;
    logic [VAL_W-1:0] w_diff_abs;

    logic w_adv;

    // Front stages
    logic                        r_a_valid, r_b_valid, r_c_valid;
    t_comp                       r_a_cmp, r_b_cmp, r_c_cmp;
    t_comp                       n_a_cmp;
    logic [N_COMP-1:0][63:0]     r_b_sq;
    logic [66:0]                 r_c_s;
    logic [63:0]                 w_sum1, w_sum2;

    // Arithmetic units
    logic              u1_valid, u2_valid, u3_valid, u4_valid, u5_valid;
    logic [33:0]       u1_root;
    logic [49:0]       u2_quo;
    logic [32:0]       u3_root;
    logic [30:0]       u4_quo;
    logic [30:0]       u5_quo;
    logic [CMP_W-1:0]  u1_side, u2_side, u3_side, u4_side;
    logic [CMP_W:0]    u5_side;

    // Viscosity stages
    logic              r_k_valid, r_m_valid, r_n_valid, r_p_valid, r_q_valid;
    t_comp             r_k_cmp, r_m_cmp, r_n_cmp, r_p_cmp, r_q_cmp;
    logic [VAL_W-1:0]  r_k;
    logic [47:0]       r_m_kh;
    logic [VAL_W-1:0]  r_n_mag;
    logic [61:0]       r_p_sq;
    logic [61:0]       r_q_sq;
    logic              r_q_ovf;
    logic [31:0]       w_den;
    logic [VAL_W-1:0]  w_a;

    // Product stage
    logic                    r_r_valid;
    logic [N_COMP-1:0]       r_r_neg;
    logic [N_COMP-1:0][62:0] r_r_prod;
    logic [VAL_W-1:0]        r_r_mu;
    logic [63:0]             r_r_bulk;
    logic                    r_r_sat;
    t_comp                   w_r_cmp;
    logic                    w_r_ovf;
    logic [VAL_W-1:0]        w_mu;

    // Output register
    logic                          r_out_valid;
    logic [N_COMP-1:0][DATA_W-1:0] r_out_s, n_out_s;
    logic [VAL_W-1:0]              r_out_shear, r_out_bulk;
    logic                          r_out_sat, n_out_sat;
    logic                          w_out_load;

    // Configuration writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu0  <= '0;
            r_h    <= '0;
            r_k0   <= '0;
            r_kinf <= '0;
            r_gc   <= ONE_FX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MU0:  r_mu0  <= i_cfg_data[VAL_W-1:0];
                REG_H:    r_h    <= i_cfg_data[H_W-1:0];
                REG_K0:   r_k0   <= i_cfg_data[VAL_W-1:0];
                REG_KINF: r_kinf <= i_cfg_data[VAL_W-1:0];
                REG_GC:   r_gc   <= i_cfg_data[VAL_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        w_gc_eff   = (r_gc == '0) ? VAL_W'(1) : r_gc;
        w_diff_neg = (r_k0 < r_kinf);
        w_diff_abs = w_diff_neg ? (r_kinf - r_k0) : (r_k0 - r_kinf);
    end

    // Advance unless the output is stalled and the last stage holds an item
    assign w_adv           = !r_out_valid || i_m_axis_tready || !r_r_valid;
    assign w_out_load      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // Stage A: split signs and magnitudes
    always_comb begin
        for (int i = 0; i < N_COMP; i++) begin
            n_a_cmp.neg[i] = i_s_axis_tdata[DATA_W*i + DATA_W-1];
            n_a_cmp.mag[i] = n_a_cmp.neg[i] ? (DATA_W'(0) - i_s_axis_tdata[DATA_W*i +: DATA_W])
                                            : i_s_axis_tdata[DATA_W*i +: DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_s_axis_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Stages B and C: squares, then the weighted sum 2*tr(D^2)
    always_comb begin
        w_sum1 = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        w_sum2 = r_b_sq[3] + r_b_sq[4] + r_b_sq[5];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_cmp <= n_a_cmp;
            for (int i = 0; i < N_COMP; i++) begin
                r_b_sq[i] <= 64'(r_a_cmp.mag[i]) * 64'(r_a_cmp.mag[i]);
            end
            r_b_cmp <= r_a_cmp;
            r_c_s   <= 67'({w_sum1, 1'b0}) + 67'({w_sum2, 2'b00});
            r_c_cmp <= r_b_cmp;
        end
    end

    // Shear rate
    qvs_isqrt #(.IW(67), .SW(CMP_W)) u_sqrt_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_c_valid),
        .i_rad   (r_c_s),
        .i_side  (r_c_cmp),
        .o_valid (u1_valid),
        .o_root  (u1_root),
        .o_side  (u1_side)
    );

    // Rate over critical rate
    qvs_divu #(.NW(50), .DW(VAL_W), .QW(50), .SW(CMP_W)) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (u1_valid),
        .i_num   ({u1_root, 16'd0}),
        .i_den   (w_gc_eff),
        .i_side  (u1_side),
        .o_valid (u2_valid),
        .o_quo   (u2_quo),
        .o_side  (u2_side)
    );

    // r = sqrt of the rate ratio
    qvs_isqrt #(.IW(66), .SW(CMP_W)) u_sqrt_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (u2_valid),
        .i_rad   ({u2_quo, 16'd0}),
        .i_side  (u2_side),
        .o_valid (u3_valid),
        .o_root  (u3_root),
        .o_side  (u3_side)
    );

    // |k0 - kinf| / (1 + r)
    qvs_divu #(.NW(47), .DW(34), .QW(31), .SW(CMP_W)) u_div_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (u3_valid),
        .i_num   ({w_diff_abs, 16'd0}),
        .i_den   (34'(u3_root) + 34'(ONE_FX)),
        .i_side  (u3_side),
        .o_valid (u4_valid),
        .o_quo   (u4_quo),
        .o_side  (u4_side)
    );

    // Stages K to Q: k, k*H, |1 - k*H/2|, its square, overflow test
    always_comb begin
        w_a   = r_m_kh[47:17];
        w_den = 32'(ONE_FX) - {1'b0, w_a};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_n_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
        end else if (w_adv) begin
            r_k_valid <= u4_valid;
            r_m_valid <= r_k_valid;
            r_n_valid <= r_m_valid;
            r_p_valid <= r_n_valid;
            r_q_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k      <= w_diff_neg ? (r_kinf - u4_quo) : (r_kinf + u4_quo);
            r_k_cmp  <= u4_side;
            r_m_kh   <= 48'(r_k) * 48'(r_h);
            r_m_cmp  <= r_k_cmp;
            r_n_mag  <= w_den[31] ? VAL_W'(32'd0 - w_den) : w_den[VAL_W-1:0];
            r_n_cmp  <= r_m_cmp;
            r_p_sq   <= 62'(r_n_mag) * 62'(r_n_mag);
            r_p_cmp  <= r_n_cmp;
            // Quotient would not fit in 31 bits, or the denominator is zero
            r_q_ovf  <= (93'({r_mu0, 32'd0}) >= {r_p_sq, 31'd0});
            r_q_sq   <= r_p_sq;
            r_q_cmp  <= r_p_cmp;
        end
    end

    // Viscosity mu0 * 2^32 / den^2
    qvs_divu #(.NW(63), .DW(62), .QW(31), .SW(CMP_W + 1)) u_div_mu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_q_valid),
        .i_num   ({r_mu0, 32'd0}),
        .i_den   (r_q_sq),
        .i_side  ({r_q_ovf, r_q_cmp}),
        .o_valid (u5_valid),
        .o_quo   (u5_quo),
        .o_side  (u5_side)
    );

    // Stage R: stress and bulk products
    always_comb begin
        w_r_cmp = u5_side[CMP_W-1:0];
        w_r_ovf = u5_side[CMP_W];
        w_mu    = w_r_ovf ? VAL_MAX : u5_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (w_adv) begin
            r_r_valid <= u5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < N_COMP; i++) begin
                r_r_prod[i] <= 63'(w_mu) * 63'(w_r_cmp.mag[i]);
            end
            r_r_neg  <= w_r_cmp.neg;
            r_r_mu   <= w_mu;
            r_r_bulk <= 64'({w_mu, 1'b0}) * 64'(RECIP3);
            r_r_sat  <= w_r_ovf;
        end
    end

    // Output stage: scale by 2/2^16, clip and restore sign
    always_comb begin
        logic [47:0] mag;
        n_out_sat = r_r_sat;
        for (int i = 0; i < N_COMP; i++) begin
            mag = r_r_prod[i][62:15];
            if (r_r_neg[i]) begin
                if (mag > 48'(VAL_MAX) + 48'd1) begin
                    mag       = 48'(VAL_MAX) + 48'd1;
                    n_out_sat = 1'b1;
                end
                n_out_s[i] = DATA_W'(0) - mag[DATA_W-1:0];
            end else begin
                if (mag > 48'(VAL_MAX)) begin
                    mag       = 48'(VAL_MAX);
                    n_out_sat = 1'b1;
                end
                n_out_s[i] = mag[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_s     <= n_out_s;
            r_out_shear <= r_r_mu;
            r_out_bulk  <= r_r_bulk[63:33];
            r_out_sat   <= n_out_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_sat, r_out_bulk, r_out_shear, r_out_s};

    // Checks on the pipeline control and the saturation path
    `QVS_ASSERT_NOW(a_ready_only_on_stall, !o_s_axis_tready,
        r_out_valid && !i_m_axis_tready && r_r_valid, "input stalled without output stall")
    `QVS_ASSERT_NEXT(a_last_stage_held, !w_adv, r_r_valid && $stable(r_r_mu),
        "last stage changed during stall")
    `QVS_ASSERT_NEXT(a_ovf_saturates, w_out_load && r_r_valid && r_r_sat,
        r_out_valid && r_out_sat && (r_out_shear == VAL_MAX), "overflow not saturated")
    `QVS_ASSERT_NOW(a_bulk_below_shear, r_out_valid, r_out_bulk <= r_out_shear,
        "bulk viscosity above shear viscosity")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import qvs_pkg::*;

    localparam int          CLK_HALF    = 4;
    localparam int          WATCH_LIMIT = 20000;
    localparam int          DRAIN_WAIT  = 250;
    localparam logic [2:0]  IDX_UNUSED  = 3'd6;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [191:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [255:0] o_m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    quemada_viscous_stress uut (.*);

    always #CLK_HALF i_clk = ~i_clk;

    // Register mirror
    logic [30:0] mu0_q;
    logic [16:0] frac_q;
    logic [30:0] k0_q;
    logic [30:0] kinf_q;
    logic [30:0] gc_q;

    logic [191:0] tensor_q[$];
    logic [255:0] stress_due[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    logic         in_taken = 1'b0;

    function automatic logic [63:0] int_sqrt(input logic [127:0] x);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            sq = 128'(trial) * 128'(trial);
            if (sq <= x) root = trial;
        end
        return root;
    endfunction

    // Quemada viscosity and stress for one tensor
    function automatic logic [255:0] quemada_stress(input logic [191:0] td);
        logic [63:0]  mag[6];
        logic         neg[6];
        logic [127:0] sum_sq;
        logic [63:0]  gdot, quot, root, t, a, mu, dm, s;
        logic [31:0]  cr;
        logic signed [63:0] diff, k, den;
        logic         sat;
        logic [255:0] res;
        sum_sq = '0;
        sat = 1'b0;
        res = '0;
        for (int i = 0; i < 6; i++) begin
            neg[i] = td[32*i+31];
            mag[i] = neg[i] ? 64'd0 - 64'($signed(td[32*i +: 32])) : 64'(td[32*i +: 32]);
            sum_sq += (i < 3 ? 128'd2 : 128'd4) * 128'(mag[i]) * 128'(mag[i]);
        end
        gdot = int_sqrt(sum_sq);
        // zero critical rate behaves as the smallest step
        cr = (gc_q == 0) ? 32'd1 : 32'(gc_q);
        quot = (gdot << FRAC_W) / 64'(cr);
        root = int_sqrt(128'(quot) << FRAC_W);
        diff = $signed(64'(k0_q)) - $signed(64'(kinf_q));
        dm = diff < 0 ? 64'(-diff) : 64'(diff);
        t = (dm << FRAC_W) / (64'h1_0000 + root);
        k = diff < 0 ? $signed(64'(kinf_q)) - $signed(t) : $signed(64'(kinf_q)) + $signed(t);
        a = (64'(k) * 64'(frac_q)) >> (FRAC_W + 1);
        den = 64'sh1_0000 - $signed(a);
        if (den == 0) begin
            mu = 64'(VAL_MAX);
            sat = 1'b1;
        end else begin
            dm = den < 0 ? 64'(-den) : 64'(den);
            mu = (64'(mu0_q) << (2 * FRAC_W)) / (dm * dm);
            if (mu > 64'(VAL_MAX)) begin
                mu = 64'(VAL_MAX);
                sat = 1'b1;
            end
        end
        for (int i = 0; i < 6; i++) begin
            s = (64'd2 * mu * mag[i]) >> FRAC_W;
            if (neg[i]) begin
                if (s > 64'h8000_0000) begin
                    s = 64'h8000_0000;
                    sat = 1'b1;
                end
                s = 64'd0 - s;
            end else if (s > 64'h7FFF_FFFF) begin
                s = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            res[32*i +: 32] = s[31:0];
        end
        res[192 +: 31] = mu[30:0];
        res[223 +: 31] = 31'((64'd2 * mu) / 64'd3);
        res[254] = sat;
        return res;
    endfunction

    // Input side: predict the result of each accepted tensor
    always @(posedge i_clk) begin
        in_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            stress_due.push_back(quemada_stress(i_s_axis_tdata));
    end

    // Driver: advance to the next tensor after a transfer, idle at random, stall the output at random
    always @(negedge i_clk) begin
        if (!i_s_axis_tvalid || in_taken) begin
            if (i_rst_n && tensor_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= tensor_q.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        logic [255:0] want;
        logic         bad;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (stress_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_m_axis_tdata);
            end else begin
                want = stress_due.pop_front();
                bad = 1'b0;
                for (int i = 0; i < 6; i++)
                    if (o_m_axis_tdata[32*i +: 32] !== want[32*i +: 32]) bad = 1'b1;
                if (o_m_axis_tdata[192 +: 31] !== want[192 +: 31]) bad = 1'b1;
                if (o_m_axis_tdata[223 +: 31] !== want[223 +: 31]) bad = 1'b1;
                if (o_m_axis_tdata[254] !== want[254]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, o_m_axis_tdata);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MU0:  mu0_q = val[30:0];
            REG_H:    frac_q = val[16:0];
            REG_K0:   k0_q = val[30:0];
            REG_KINF: kinf_q = val[30:0];
            REG_GC:   gc_q = val[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input logic [31:0] m, input logic [31:0] h,
                           input logic [31:0] k0, input logic [31:0] ki,
                           input logic [31:0] g);
        write_reg(REG_MU0, m);
        write_reg(REG_H, h);
        write_reg(REG_K0, k0);
        write_reg(REG_KINF, ki);
        write_reg(REG_GC, g);
    endtask

    function automatic logic [31:0] rand_comp();
        logic [31:0] v;
        if ($urandom_range(4) == 0) return $urandom;
        v = $urandom >> $urandom_range(31, 8);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic queue_random(input int n);
        logic [191:0] td;
        repeat (n) begin
            for (int i = 0; i < 6; i++) td[32*i +: 32] = rand_comp();
            tensor_q.push_back(td);
        end
    endtask

    // Let the pipeline empty before touching the registers
    task automatic drain();
        wait (tensor_q.size() == 0 && !i_s_axis_tvalid && stress_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        mu0_q = '0;
        frac_q = '0;
        k0_q = '0;
        kinf_q = '0;
        gc_q = 31'(ONE_FX);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (ph)
                // reset values first
                0: ;
                1: set_all(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000,
                           32'h0001_0000);
                2: set_all(32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
                // zero critical rate, volume fraction above one, ignored index
                3: begin
                    set_all(32'h0000_0400, 32'h0001_FFFF, 32'h0, 32'h0000_8000, 32'h0);
                    write_reg(IDX_UNUSED, 32'h1234_5678);
                end
                // k fixed at 2.0 with H of one: zero denominator
                default: set_all(32'h0000_0010, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
                                 32'h0000_0100);
            endcase
            // extremes of the components
            tensor_q.push_back('0);
            tensor_q.push_back({6{32'h7FFF_FFFF}});
            tensor_q.push_back({6{32'h8000_0000}});
            tensor_q.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000});
            for (int i = 0; i < 6; i++) tensor_q.push_back(192'(32'h0001_0000) << (32 * i));
            queue_random(145);
            drain();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### quemada_viscous_stress.f
+incdir+rtl
rtl/qvs_pkg.sv
rtl/qvs_isqrt.sv
rtl/qvs_divu.sv
rtl/quemada_viscous_stress.sv
tb/testbench.sv
